// ===== hw/rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// shared types and constants of the gradient color map
// ----------------------------------------------------------------------------
package gcm_pkg;

   localparam int MAX_STOPS_DEF = 8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   localparam logic [2:0] REG_ADDR_MODE  = 3'd0;
   localparam logic [2:0] REG_ADDR_COUNT = 3'd4;

   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [18:0] HUE_TURN = 19'd393216;

   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 17;

   typedef struct packed {
      logic [16:0] pos;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } stop_type;

   typedef struct packed {
      logic       is_map;
      logic [2:0] idx;
      stop_type   stop;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

// ===== hw/rtl/gcm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_front
// accepts request words, drops out of range stop writes, two-entry queue
// ----------------------------------------------------------------------------
module gcm_front #(
   parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [2:0]            req_stop_index,
   input  logic [16:0]           req_position,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   output gcm_pkg::queue_out_type q_out,
   input  logic                  q_pop
);

   gcm_pkg::item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep;
   logic       push;
   logic       pop;
   gcm_pkg::item_type new_item;

   always_comb begin
      keep = (req_opcode == gcm_pkg::OP_MAP) ||
             ((32'(req_stop_index) < MAX_STOPS) && (req_position <= gcm_pkg::ONE_Q16));
      new_item.is_map     = (req_opcode == gcm_pkg::OP_MAP);
      new_item.idx        = req_stop_index;
      new_item.stop.pos   = req_position;
      new_item.stop.red   = req_red_in;
      new_item.stop.green = req_green_in;
      new_item.stop.blue  = req_blue_in;
      busy = (cnt_ff == 2'd2);
      push = start && !busy && keep;
      pop  = q_pop && (cnt_ff != 2'd0);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      q_out.valid = (cnt_ff != 2'd0);
      q_out.item  = q_mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hw/rtl/gcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gcm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           div_start,
   input  logic [gcm_pkg::DIV_NUM_W-1:0]  div_num,
   input  logic [gcm_pkg::DIV_DEN_W-1:0]  div_den,
   output logic                           div_done,
   output logic [gcm_pkg::DIV_NUM_W-1:0]  div_quo
);

   localparam int NW = gcm_pkg::DIV_NUM_W;
   localparam int DW = gcm_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_sh;
   logic          fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_start) begin
         cnt_in = CW'(NW);
         run_in = 1'b1;
         quo_in = div_num;
         rem_in = '0;
         den_in = div_den;
      end else if (run_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

// ===== hw/rtl/gcm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_back
// stop table, span search and rgb / hsl interpolation sequencer
// ----------------------------------------------------------------------------
module gcm_back #(
   parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gcm_pkg::queue_out_type q_out,
   output logic                   q_pop,
   input  logic                   interp_mode,
   input  logic [3:0]             stop_count,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_red_out,
   output logic [7:0]             rsp_green_out,
   output logic [7:0]             rsp_blue_out
);

   localparam int AW = $clog2(MAX_STOPS);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RD0    = 13'b0000000000010,
      S_RDL    = 13'b0000000000100,
      S_SCAN   = 13'b0000000001000,
      S_DIVT   = 13'b0000000010000,
      S_MIXRGB = 13'b0000000100000,
      S_FGO    = 13'b0000001000000,
      S_FWAIT  = 13'b0000010000000,
      S_MIXH   = 13'b0000100000000,
      S_CQ     = 13'b0001000000000,
      S_XS     = 13'b0010000000000,
      S_HOUT   = 13'b0100000000000,
      S_EMIT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   gcm_pkg::stop_type mem [MAX_STOPS];
   gcm_pkg::stop_type rd_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;

   gcm_pkg::stop_type lo_ff, lo_in, hi_ff, hi_in;
   logic [16:0] v_ff, v_in;
   logic [3:0]  n_ff, n_in;
   logic [3:0]  k_ff, k_in;
   logic [16:0] t_ff, t_in;
   logic [1:0]  ch_ff, ch_in;
   logic        side_ff, side_in;
   logic [1:0]  step_ff, step_in;
   logic [7:0]  res_ff [3];
   logic [7:0]  res_in [3];
   logic [18:0] h_ff [2];
   logic [16:0] s_ff [2];
   logic [16:0] l_ff [2];
   logic [18:0] h_in [2];
   logic [16:0] s_in [2];
   logic [16:0] l_in [2];
   logic [18:0] mh_ff, mh_in;
   logic [16:0] ms_ff, ms_in;
   logic [16:0] ml_ff, ml_in;
   logic [16:0] cq_ff, cq_in;
   logic [16:0] x_ff, x_in;

   logic [3:0]  n_new;
   logic        div_start;
   logic [gcm_pkg::DIV_NUM_W-1:0] div_num;
   logic [gcm_pkg::DIV_DEN_W-1:0] div_den;
   logic        div_done;
   logic [gcm_pkg::DIV_NUM_W-1:0] div_quo;

   logic [18:0] mix_a, mix_b, mix_r;
   logic signed [19:0] mix_d;
   logic signed [37:0] mix_p;
   logic signed [39:0] mix_acc;

   gcm_pkg::stop_type fcol;
   logic [7:0]  f_mx, f_mn, f_chroma, f_a, f_b, f_diff;
   logic [8:0]  f_sum, f_den;
   logic [2:0]  f_base;
   logic        f_neg;
   logic [16:0] f_q;
   logic [18:0] f_hue;
   logic [15:0] f_m;
   logic [16:0] f_lum;
   logic [16:0] vd;
   logic [16:0] span;

   logic [17:0] w;
   logic [34:0] cq_prod;
   logic [33:0] x_prod;
   logic [2:0]  sector;
   logic [16:0] fr, f_sel;
   logic [16:0] part [3];

   function automatic logic [7:0] chan(input logic [16:0] p, input logic [16:0] l,
                                       input logic [16:0] cq);
      logic [18:0] v;
      logic [26:0] prod;
      logic [9:0]  o;
      v    = 19'({p, 1'b0}) + 19'({l, 1'b0}) - 19'(cq);
      prod = 27'({v, 8'h00}) - 27'(v) + 27'd65536;
      o    = prod[26:17];
      return (o > 10'd255) ? 8'd255 : o[7:0];
   endfunction

   gcm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   always_comb begin
      mix_d   = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
      mix_p   = mix_d * $signed({1'b0, t_ff});
      mix_acc = $signed({5'b0, mix_a, 16'h0000}) + {{2{mix_p[37]}}, mix_p} + 40'sd32768;
      mix_r   = mix_acc[34:16];
   end

   always_comb begin
      fcol     = side_ff ? hi_ff : lo_ff;
      f_mx     = fcol.red;
      f_mn     = fcol.red;
      if (fcol.green > f_mx) f_mx = fcol.green;
      if (fcol.blue > f_mx) f_mx = fcol.blue;
      if (fcol.green < f_mn) f_mn = fcol.green;
      if (fcol.blue < f_mn) f_mn = fcol.blue;
      f_chroma = f_mx - f_mn;
      f_sum    = {1'b0, f_mx} + {1'b0, f_mn};
      f_den    = (f_sum <= 9'd255) ? f_sum : 9'd510 - f_sum;
      // lightness: 128*sum + (128*sum + 127) / 255
      f_m      = {f_sum, 7'd0} + 16'd127;
      f_lum    = 17'({f_sum, 7'd0}) + 17'((17'(f_m) + 17'd1 + 17'(f_m[15:8])) >> 8);
      if (f_mx == fcol.red) begin
         f_base = 3'd0; f_a = fcol.green; f_b = fcol.blue;
      end else if (f_mx == fcol.green) begin
         f_base = 3'd2; f_a = fcol.blue; f_b = fcol.red;
      end else begin
         f_base = 3'd4; f_a = fcol.red; f_b = fcol.green;
      end
      f_neg  = (f_a < f_b);
      f_diff = f_neg ? f_b - f_a : f_a - f_b;
      f_q    = div_quo[16:0];
      if (!f_neg) begin
         f_hue = {f_base, 16'h0000} + 19'(f_q);
      end else if (f_base == 3'd0) begin
         f_hue = gcm_pkg::HUE_TURN - 19'(f_q);
      end else begin
         f_hue = {f_base, 16'h0000} - 19'(f_q);
      end
      vd   = v_ff - lo_ff.pos;
      span = rd_ff.pos - lo_ff.pos;
   end

   always_comb begin
      w       = ({ml_ff, 1'b0} <= 18'(gcm_pkg::ONE_Q16)) ? {ml_ff, 1'b0}
                                                         : 18'd131072 - {ml_ff, 1'b0};
      cq_prod = 35'(w * ms_ff) + 35'd32768;
      fr      = {1'b0, mh_ff[15:0]};
      case (mh_ff[18:16])
         3'd6:    sector = 3'd0;
         3'd7:    sector = 3'd1;
         default: sector = mh_ff[18:16];
      endcase
      f_sel  = sector[0] ? gcm_pkg::ONE_Q16 - fr : fr;
      x_prod = 34'(cq_ff * f_sel) + 34'd32768;
      case (sector)
         3'd0:    begin part[0] = cq_ff; part[1] = x_ff;  part[2] = '0;    end
         3'd1:    begin part[0] = x_ff;  part[1] = cq_ff; part[2] = '0;    end
         3'd2:    begin part[0] = '0;    part[1] = cq_ff; part[2] = x_ff;  end
         3'd3:    begin part[0] = '0;    part[1] = x_ff;  part[2] = cq_ff; end
         3'd4:    begin part[0] = x_ff;  part[1] = '0;    part[2] = cq_ff; end
         default: begin part[0] = cq_ff; part[1] = '0;    part[2] = x_ff;  end
      endcase
   end

   always_comb begin
      n_new = (32'(stop_count) > MAX_STOPS) ? 4'(MAX_STOPS) : stop_count;
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff; v_in = v_ff; n_in = n_ff; k_in = k_ff;
      t_in = t_ff; ch_in = ch_ff; side_in = side_ff; step_in = step_ff;
      res_in = res_ff; h_in = h_ff; s_in = s_ff; l_in = l_ff;
      mh_in = mh_ff; ms_in = ms_ff; ml_in = ml_ff; cq_in = cq_ff; x_in = x_ff;
      q_pop = 1'b0;
      mem_we = 1'b0;
      rd_addr = '0;
      div_start = 1'b0;
      div_num = 33'({vd, 16'h0000});
      div_den = span;
      mix_a = '0;
      mix_b = '0;
      case (ch_ff)
         2'd0:    begin mix_a = 19'(lo_ff.red);   mix_b = 19'(hi_ff.red);   end
         2'd1:    begin mix_a = 19'(lo_ff.green); mix_b = 19'(hi_ff.green); end
         default: begin mix_a = 19'(lo_ff.blue);  mix_b = 19'(hi_ff.blue);  end
      endcase
      if (state_ff == S_MIXH) begin
         case (ch_ff)
            2'd0:    begin mix_a = h_ff[0];        mix_b = h_ff[1];        end
            2'd1:    begin mix_a = 19'(s_ff[0]);   mix_b = 19'(s_ff[1]);   end
            default: begin mix_a = 19'(l_ff[0]);   mix_b = 19'(l_ff[1]);   end
         endcase
      end
      if (state_ff == S_FGO) begin
         case (step_ff)
            2'd1: begin
               div_num = 33'({f_chroma, 16'h0000}) + 33'(f_den >> 1);
               div_den = 17'(f_den);
            end
            default: begin
               div_num = 33'({f_diff, 16'h0000}) + 33'(f_chroma >> 1);
               div_den = 17'(f_chroma);
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop = 1'b1;
               if (!q_out.item.is_map) begin
                  mem_we = 1'b1;
               end else begin
                  v_in = q_out.item.stop.pos;
                  n_in = n_new;
                  if (n_new == 4'd0) begin
                     for (int i = 0; i < 3; i++) res_in[i] = 8'd0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_RD0;
                  end
               end
            end
         end
         S_RD0: begin
            lo_in = rd_ff;
            if ((n_ff == 4'd1) || (v_ff < rd_ff.pos)) begin
               res_in[0] = rd_ff.red; res_in[1] = rd_ff.green; res_in[2] = rd_ff.blue;
               state_in = S_EMIT;
            end else begin
               rd_addr = AW'(n_ff - 4'd1);
               state_in = S_RDL;
            end
         end
         S_RDL: begin
            if (v_ff > rd_ff.pos) begin
               res_in[0] = rd_ff.red; res_in[1] = rd_ff.green; res_in[2] = rd_ff.blue;
               state_in = S_EMIT;
            end else begin
               k_in = 4'd1;
               rd_addr = AW'(4'd1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if ((k_ff < n_ff - 4'd1) && (v_ff > rd_ff.pos)) begin
               lo_in = rd_ff;
               k_in = k_ff + 4'd1;
               rd_addr = AW'(k_ff + 4'd1);
            end else begin
               hi_in = rd_ff;
               if (rd_ff.pos <= lo_ff.pos) begin
                  res_in[0] = rd_ff.red; res_in[1] = rd_ff.green; res_in[2] = rd_ff.blue;
                  state_in = S_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in = S_DIVT;
               end
            end
         end
         S_DIVT: begin
            if (div_done) begin
               t_in = (div_quo > 33'(gcm_pkg::ONE_Q16)) ? gcm_pkg::ONE_Q16 : div_quo[16:0];
               ch_in = 2'd0;
               side_in = 1'b0;
               step_in = 2'd0;
               state_in = interp_mode ? S_FGO : S_MIXRGB;
            end
         end
         S_MIXRGB: begin
            res_in[ch_ff] = mix_r[7:0];
            ch_in = ch_ff + 2'd1;
            if (ch_ff == 2'd2) state_in = S_EMIT;
         end
         S_FGO: begin
            if (step_ff == 2'd0) begin
               l_in[side_ff] = f_lum;
               if (f_chroma == 8'd0) begin
                  h_in[side_ff] = '0;
                  s_in[side_ff] = '0;
                  side_in = 1'b1;
                  if (side_ff) begin
                     ch_in = 2'd0;
                     state_in = S_MIXH;
                  end
               end else begin
                  step_in = 2'd1;
               end
            end else begin
               div_start = 1'b1;
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            if (div_done) begin
               state_in = S_FGO;
               if (step_ff == 2'd1) begin
                  s_in[side_ff] = div_quo[16:0];
                  step_in = 2'd2;
               end else begin
                  h_in[side_ff] = f_hue;
                  step_in = 2'd0;
                  side_in = 1'b1;
                  if (side_ff) begin
                     ch_in = 2'd0;
                     state_in = S_MIXH;
                  end
               end
            end
         end
         S_MIXH: begin
            case (ch_ff)
               2'd0:    mh_in = mix_r;
               2'd1:    ms_in = mix_r[16:0];
               default: ml_in = mix_r[16:0];
            endcase
            ch_in = ch_ff + 2'd1;
            if (ch_ff == 2'd2) state_in = S_CQ;
         end
         S_CQ: begin
            cq_in = cq_prod[32:16];
            state_in = S_XS;
         end
         S_XS: begin
            x_in = x_prod[32:16];
            state_in = S_HOUT;
         end
         S_HOUT: begin
            for (int i = 0; i < 3; i++) res_in[i] = chan(part[i], ml_ff, cq_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(q_out.item.idx)] <= q_out.item.stop;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; v_ff <= v_in; n_ff <= n_in; k_ff <= k_in;
      t_ff <= t_in; ch_ff <= ch_in; side_ff <= side_in; step_ff <= step_in;
      res_ff <= res_in; h_ff <= h_in; s_ff <= s_in; l_ff <= l_in;
      mh_ff <= mh_in; ms_ff <= ms_in; ml_ff <= ml_in; cq_ff <= cq_in; x_ff <= x_in;
   end

   assign rsp_valid     = (state_ff == S_EMIT);
   assign rsp_red_out   = res_ff[0];
   assign rsp_green_out = res_ff[1];
   assign rsp_blue_out  = res_ff[2];

endmodule

// ===== hw/rtl/gradient_color_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_map
// maps a q1.16 scalar to an rgb color through a table of color stops
// ----------------------------------------------------------------------------
// a request word is taken when start is high and busy is low. opcode write
// stores one stop and gives no result; opcode map gives one result word on
// rsp_* for a single cycle marked by rsp_valid. the receiver cannot stall.
// words wait in a two-entry queue; busy is high while it is full.
// a stop write is taken by the back end when idle. a map with no stops
// gives black; with one stop or below the first stop it gives the first
// stop's color, above the last stop the last one's; else a span search
// finds the two stops around it, the shared bit-serial divider gives the
// fraction and rgb or hsl mixing follows. hsl needs two divisions per
// colored stop and none per gray stop.
// interp_mode sits at byte 0 and stop_count at byte 4 of the apb port; both
// reset to 0. after reset the queue is empty and the stop table is unset.
// ----------------------------------------------------------------------------
module gradient_color_map #(
   parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [2:0]  req_stop_index,
   input  logic [16:0] req_position,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       mode_ff, mode_in;
   logic [3:0] count_ff, count_in;
   logic       wr_en;
   gcm_pkg::queue_out_type q_out;
   logic       q_pop;

   always_comb begin
      pready   = 1'b1;
      wr_en    = psel && penable && pwrite;
      mode_in  = mode_ff;
      count_in = count_ff;
      if (wr_en && (paddr == gcm_pkg::REG_ADDR_MODE)) mode_in = pwdata[0];
      if (wr_en && (paddr == gcm_pkg::REG_ADDR_COUNT)) count_in = pwdata[3:0];
      case (paddr)
         gcm_pkg::REG_ADDR_MODE:  prdata = {31'd0, mode_ff};
         gcm_pkg::REG_ADDR_COUNT: prdata = {28'd0, count_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= 4'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   gcm_front #(.MAX_STOPS(MAX_STOPS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_stop_index (req_stop_index),
      .req_position   (req_position),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .q_out          (q_out),
      .q_pop          (q_pop)
   );

   gcm_back #(.MAX_STOPS(MAX_STOPS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_out         (q_out),
      .q_pop         (q_pop),
      .interp_mode   (mode_ff),
      .stop_count    (count_ff),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

endmodule
